// File: rtl/tqs_pkg.sv
package tqs_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int ID_WIDTH   = 4;
   localparam int MASK_WIDTH = 16;
   localparam int CMD_WIDTH  = 3;
   localparam int STS_WIDTH  = 2;
   localparam int OCNT_WIDTH = 5;

   // command codes
   localparam logic [CMD_WIDTH-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_POP    = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_READY  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_PEEK   = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_COUNT  = 3'd5;

   // status codes
   localparam logic [STS_WIDTH-1:0] STS_OK        = 2'd0;
   localparam logic [STS_WIDTH-1:0] STS_EMPTY     = 2'd1;
   localparam logic [STS_WIDTH-1:0] STS_FULL      = 2'd2;
   localparam logic [STS_WIDTH-1:0] STS_NOT_READY = 2'd3;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  cmd;
      logic [ID_WIDTH-1:0]   task_id;
      logic [TIME_WIDTH-1:0] start_time;
      logic [MASK_WIDTH-1:0] ready_mask;
      logic [TIME_WIDTH-1:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [STS_WIDTH-1:0]  status;
      logic [ID_WIDTH-1:0]   out_task_id;
      logic [TIME_WIDTH-1:0] out_start_time;
      logic [OCNT_WIDTH-1:0] due_count;
      logic [OCNT_WIDTH-1:0] occupancy;
   } rsp_type;

   // one queue slot as seen between neighboring cells
   typedef struct packed {
      logic                  valid;
      logic [ID_WIDTH-1:0]   task_id;
      logic [TIME_WIDTH-1:0] start_time;
   } slot_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic sample;      // latch compare flags
      logic load;        // take the new item
      logic take_left;   // shift toward the back
      logic take_right;  // shift toward the front
   } cell_ctrl_type;

   // per-cell compare results
   typedef struct packed {
      logic gt;   // new start time strictly below this slot's
      logic due;  // this slot's start time strictly below elapsed
      logic rdy;  // this slot's task is in the ready mask
   } cell_flag_type;

endpackage

// File: rtl/task_queue_sorted_ready_pop.sv
// Each accepted item passes a compare step, which latches the cell flags, and then an
//   execute step, which shifts the cell row and registers the result. A new item is
//   taken only once the block is back in idle. A stalled result holds the execute
//   step until the output register frees.
// Reset: synchronous, active high; empties the queue and drops any item in flight.
module task_queue_sorted_ready_pop #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tqs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tqs_pkg::rsp_type rsp_payload
);
   import tqs_pkg::*;

   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   req_type                req_ff;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic [CNT_WIDTH-1:0]   count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   // cell row
   slot_type               slots     [DEPTH];
   cell_flag_type          flags     [DEPTH];
   cell_ctrl_type          ctrls     [DEPTH];
   slot_type               left_in   [DEPTH];
   slot_type               right_in  [DEPTH];

   logic [DEPTH-1:0]       valid_vec;
   logic [DEPTH-1:0]       due_vec;
   logic [DEPTH-1:0]       sel_ins;     // insert candidates: empty slot, or later start time
   logic [DEPTH-1:0]       sel_rdy;     // ready candidates
   logic [DEPTH-1:0]       before_ins;  // a candidate sits ahead of this cell
   logic [DEPTH-1:0]       before_rdy;
   logic [DEPTH-1:0]       first_rdy;
   logic [DEPTH-1:0]       therm;       // expected valid pattern for the count

   logic                   accept;
   logic                   go;
   logic                   full;
   logic                   empty;
   logic                   found;
   logic                   do_ins;
   logic                   do_pop;
   logic                   do_rdy;
   logic [ID_WIDTH-1:0]    pick_id;
   logic [TIME_WIDTH-1:0]  pick_time;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // execute fires only once the output register can take the result
   assign go    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         localparam logic [DEPTH-1:0] LOW_MASK =
            (gi == 0) ? '0 : ({DEPTH{1'b1}} >> (DEPTH - gi));

         // cell 0 never shifts toward the back; the last cell pulls in an empty slot
         if (gi == 0) begin : g_first
            assign left_in[gi] = '0;
         end else begin : g_mid_l
            assign left_in[gi] = slots[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_in[gi] = '0;
         end else begin : g_mid_r
            assign right_in[gi] = slots[gi+1];
         end

         assign valid_vec[gi]  = slots[gi].valid;
         assign due_vec[gi]    = flags[gi].due;
         assign sel_ins[gi]    = !slots[gi].valid ||
                                 ((req_ff.cmd == CMD_INSERT) && flags[gi].gt);
         assign sel_rdy[gi]    = flags[gi].rdy;
         assign before_ins[gi] = |(sel_ins & LOW_MASK);
         assign before_rdy[gi] = |(sel_rdy & LOW_MASK);
         assign first_rdy[gi]  = sel_rdy[gi] && !before_rdy[gi];
         assign therm[gi]      = (CNT_WIDTH'(gi) < count_ff);

         // new item lands in the first candidate; everything behind it moves back
         assign ctrls[gi].sample     = (state_ff == S_CMP);
         assign ctrls[gi].load       = do_ins && sel_ins[gi] && !before_ins[gi];
         assign ctrls[gi].take_left  = do_ins && before_ins[gi];
         // removal closes the gap: the removed cell and all behind it move forward
         assign ctrls[gi].take_right = do_pop ||
                                       (do_rdy && (sel_rdy[gi] || before_rdy[gi]));

         tqs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrls[gi]),
            .left_slot  (left_in[gi]),
            .right_slot (right_in[gi]),
            .req        (req_ff),
            .slot       (slots[gi]),
            .flags      (flags[gi])
         );
      end
   endgenerate

   assign found  = |sel_rdy;
   assign do_ins = go && ((req_ff.cmd == CMD_PUSH) || (req_ff.cmd == CMD_INSERT)) && !full;
   assign do_pop = go && (req_ff.cmd == CMD_POP) && !empty;
   assign do_rdy = go && (req_ff.cmd == CMD_READY) && found;

   // one-hot pick of the first ready slot
   always_comb begin
      pick_id   = '0;
      pick_time = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pick_id   = pick_id   | ({ID_WIDTH{first_rdy[i]}}   & slots[i].task_id);
         pick_time = pick_time | ({TIME_WIDTH{first_rdy[i]}} & slots[i].start_time);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (do_pop || do_rdy) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_comb begin
      rsp_in           = '0;
      rsp_in.occupancy = OCNT_WIDTH'(count_in);
      unique case (req_ff.cmd)
         CMD_PUSH, CMD_INSERT: begin
            if (full) begin
               rsp_in.status = STS_FULL;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (empty) begin
               rsp_in.status = STS_EMPTY;
            end else begin
               rsp_in.out_task_id    = slots[0].task_id;
               rsp_in.out_start_time = slots[0].start_time;
            end
         end
         CMD_READY: begin
            if (empty) begin
               rsp_in.status = STS_EMPTY;
            end else if (!found) begin
               rsp_in.status = STS_NOT_READY;
            end else begin
               rsp_in.out_task_id    = pick_id;
               rsp_in.out_start_time = pick_time;
            end
         end
         CMD_COUNT: begin
            rsp_in.due_count = OCNT_WIDTH'($countones(due_vec));
         end
         default: begin
            // unused codes: no change, status ok
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // count never runs past the row
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("queue count beyond depth");

   // occupied cells are exactly the front count_ff cells
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      valid_vec == therm)
      else $error("cell valid bits do not match count");

   // an execute step always leaves a result in the output register
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("execute without result");

   // an accepted item moves straight to the compare pass
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CMP))
      else $error("accepted item did not start compare");

endmodule

// File: rtl/tqs_cell.sv
module tqs_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tqs_pkg::cell_ctrl_type ctrl,
   input  tqs_pkg::slot_type      left_slot,
   input  tqs_pkg::slot_type      right_slot,
   input  tqs_pkg::req_type       req,
   output tqs_pkg::slot_type      slot,
   output tqs_pkg::cell_flag_type flags
);
   import tqs_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [ID_WIDTH-1:0]   id_ff;
   logic [ID_WIDTH-1:0]   id_in;
   logic [TIME_WIDTH-1:0] time_ff;
   logic [TIME_WIDTH-1:0] time_in;
   cell_flag_type         flags_ff;
   cell_flag_type         flags_in;

   always_comb begin
      priority if (ctrl.load) begin
         valid_in = 1'b1;
         id_in    = req.task_id;
         time_in  = req.start_time;
      end else if (ctrl.take_left) begin
         valid_in = left_slot.valid;
         id_in    = left_slot.task_id;
         time_in  = left_slot.start_time;
      end else if (ctrl.take_right) begin
         valid_in = right_slot.valid;
         id_in    = right_slot.task_id;
         time_in  = right_slot.start_time;
      end else begin
         valid_in = valid_ff;
         id_in    = id_ff;
         time_in  = time_ff;
      end
   end

   always_comb begin
      flags_in     = flags_ff;
      if (ctrl.sample) begin
         flags_in.gt  = valid_ff && (req.start_time < time_ff);
         flags_in.due = valid_ff && (time_ff < req.elapsed);
         flags_in.rdy = valid_ff && req.ready_mask[id_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      time_ff  <= time_in;
      flags_ff <= flags_in;
   end

   assign slot  = '{valid: valid_ff, task_id: id_ff, start_time: time_ff};
   assign flags = flags_ff;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import tqs_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   // cmd codes the block has no operation for; it must leave the queue alone
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS = 1500;
   localparam int QUIET_ITEMS  = 150;   // tail of the run with no idling
   localparam int LONG_HOLD    = 120;   // receiver hold-off that backs up the block
   localparam int HOLD_AT_RSP  = 400;   // result count that triggers the hold-off
   localparam int IDLE_LIMIT   = 3000;  // cycles without any handshake

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_ANY} phase_kind_e;

   // Shadow copy of the task queue. note_request() applies one item and
   // queues the result it should give; check_response() pops the oldest.
   class task_queue_scoreboard;
      logic [ID_WIDTH-1:0]   slot_ids   [QUEUE_DEPTH];
      logic [TIME_WIDTH-1:0] slot_times [QUEUE_DEPTH];
      int                    fill;
      rsp_type               expected_q [$];
      int                    errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function void remove_slot(int pos);
         int i;
         for (i = pos; i + 1 < fill; i++) begin
            slot_ids[i]   = slot_ids[i + 1];
            slot_times[i] = slot_times[i + 1];
         end
         fill--;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      pos;
         int      i;
         e = '0;
         case (r.cmd)
            CMD_PUSH, CMD_INSERT: begin
               if (fill >= QUEUE_DEPTH) begin
                  e.status = STS_FULL;
               end else begin
                  pos = fill;
                  if (r.cmd == CMD_INSERT) begin
                     // ties land behind entries with the same start time
                     pos = 0;
                     while (pos < fill && !(r.start_time < slot_times[pos])) pos++;
                  end
                  for (i = fill; i > pos; i--) begin
                     slot_ids[i]   = slot_ids[i - 1];
                     slot_times[i] = slot_times[i - 1];
                  end
                  slot_ids[pos]   = r.task_id;
                  slot_times[pos] = r.start_time;
                  fill++;
               end
            end
            CMD_POP, CMD_PEEK: begin
               if (fill == 0) begin
                  e.status = STS_EMPTY;
               end else begin
                  e.out_task_id    = slot_ids[0];
                  e.out_start_time = slot_times[0];
                  if (r.cmd == CMD_POP) remove_slot(0);
               end
            end
            CMD_READY: begin
               if (fill == 0) begin
                  e.status = STS_EMPTY;
               end else begin
                  pos = 0;
                  while (pos < fill && !r.ready_mask[slot_ids[pos]]) pos++;
                  if (pos == fill) begin
                     e.status = STS_NOT_READY;
                  end else begin
                     e.out_task_id    = slot_ids[pos];
                     e.out_start_time = slot_times[pos];
                     remove_slot(pos);
                  end
               end
            end
            CMD_COUNT: begin
               for (i = 0; i < fill; i++)
                  if (slot_times[i] < r.elapsed) e.due_count++;
            end
            default: begin
            end
         endcase
         e.occupancy = OCNT_WIDTH'(fill);
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [TIME_WIDTH-1:0] want,
                                  logic [TIME_WIDTH-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type r);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, expected none actual %0h",
                     $time, r);
         end else begin
            e = expected_q.pop_front();
            compare_field("status",         e.status,         r.status);
            compare_field("out_task_id",    e.out_task_id,    r.out_task_id);
            compare_field("out_start_time", e.out_start_time, r.out_start_time);
            compare_field("due_count",      e.due_count,      r.due_count);
            compare_field("occupancy",      e.occupancy,      r.occupancy);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   task_queue_scoreboard sb = new();

   bit sender_idle_on = 1'b0;   // random gaps between items
   bit rsp_quiet      = 1'b0;   // receiver stops stalling for the tail
   int rsp_seen       = 0;
   int idle_cycles    = 0;

   task_queue_sorted_ready_pop #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Both handshakes are sampled here, with pre-edge values. The result is
   // checked before the new item is noted so a stray result can never be
   // matched against an item taken on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_payload);
            rsp_seen++;
         end
         if (req_valid && !req_stall) sb.note_request(req_payload);
      end
   end

   // Watchdog: a run that stops moving is a failure.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, open stretches, and one long hold-off
   // in the middle so the queue backs up and stalls the sender.
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && rsp_seen >= HOLD_AT_RSP) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11) - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(posedge clock);
         end
      end
   end

   // Offer one item; returns in the step of the edge that took it.
   task send_item(input req_type r);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic req_type make_req(logic [CMD_WIDTH-1:0] cmd, logic [ID_WIDTH-1:0] id,
                                        logic [TIME_WIDTH-1:0] t,
                                        logic [MASK_WIDTH-1:0] mask,
                                        logic [TIME_WIDTH-1:0] now);
      req_type r;
      r.cmd        = cmd;
      r.task_id    = id;
      r.start_time = t;
      r.ready_mask = mask;
      r.elapsed    = now;
      return r;
   endfunction

   // Times cluster near zero and near the top so ties and count edges show up.
   function automatic logic [TIME_WIDTH-1:0] rand_time();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return TIME_WIDTH'($urandom_range(0, 15));
         2:       return 32'hFFFF_FFF0 | TIME_WIDTH'($urandom_range(0, 15));
         default: return TIME_WIDTH'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [MASK_WIDTH-1:0] rand_mask();
      case ($urandom_range(0, 4))
         0:       return MASK_WIDTH'($urandom);
         1:       return MASK_WIDTH'(1) << $urandom_range(0, 15);
         2:       return MASK_WIDTH'($urandom & $urandom & $urandom);
         3:       return '0;
         default: return '1;
      endcase
   endfunction

   function automatic req_type random_req(phase_kind_e kind);
      req_type r;
      int      pick;
      r.task_id    = ID_WIDTH'($urandom_range(0, 15));
      r.start_time = rand_time();
      r.ready_mask = rand_mask();
      r.elapsed    = rand_time();
      pick = $urandom_range(0, 9);
      case (kind)
         PHASE_FILL:
            r.cmd = (pick < 3) ? CMD_PUSH : (pick < 7) ? CMD_INSERT
                                                       : CMD_WIDTH'($urandom_range(2, 5));
         PHASE_DRAIN:
            r.cmd = (pick < 3) ? CMD_POP : (pick < 6) ? CMD_READY
                                                      : CMD_WIDTH'($urandom_range(0, 5));
         default:
            r.cmd = CMD_WIDTH'($urandom_range(0, 5));
      endcase
      return r;
   endfunction

   initial begin : stimulus
      int          sent;
      int          phase_len;
      phase_kind_e kind;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty queue, spare codes, ordering, ready and count cases
      send_item(make_req(CMD_POP,    4'd0, '0, '1, '0));
      send_item(make_req(CMD_PEEK,   4'd0, '0, '1, '0));
      send_item(make_req(CMD_READY,  4'd0, '0, '1, '0));
      send_item(make_req(CMD_COUNT,  4'd0, '0, '0, '1));
      send_item(make_req(CMD_SPARE_A, 4'd9, 32'h1234_5678, '1, '1));
      send_item(make_req(CMD_SPARE_B, 4'd15, '1, '1, '1));
      send_item(make_req(CMD_PUSH,   4'd15, '1, '0, '0));
      send_item(make_req(CMD_INSERT, 4'd0, '0, '0, '0));    // lands at front
      send_item(make_req(CMD_INSERT, 4'd5, 32'd100, '0, '0));
      send_item(make_req(CMD_INSERT, 4'd6, 32'd100, '0, '0)); // tie: behind id 5
      send_item(make_req(CMD_INSERT, 4'd7, 32'd50, '0, '0));
      send_item(make_req(CMD_INSERT, 4'd9, 32'd100, '0, '0));
      send_item(make_req(CMD_PUSH,   4'd3, '0, '0, '0));    // push ignores order
      send_item(make_req(CMD_COUNT,  4'd0, '0, '0, 32'd100)); // strictly below
      send_item(make_req(CMD_COUNT,  4'd0, '0, '0, '0));
      send_item(make_req(CMD_COUNT,  4'd0, '0, '0, '1));
      send_item(make_req(CMD_READY,  4'd0, '0, 16'h0004, '0)); // no ready task
      send_item(make_req(CMD_READY,  4'd0, '0, 16'h0040, '0)); // from the middle
      send_item(make_req(CMD_READY,  4'd0, '0, 16'h8008, '0)); // first match wins
      send_item(make_req(CMD_PEEK,   4'd0, '0, '0, '0));
      send_item(make_req(CMD_POP,    4'd0, '0, '0, '0));
      send_item(make_req(CMD_SPARE_A, 4'd1, '0, '0, '0));

      // --- random phases that fill, drain or mix; tail runs with no idling
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(10, 60);
         kind      = phase_kind_e'($urandom_range(0, 2));
         if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
            sender_idle_on = 1'b0;
            rsp_quiet      = 1'b1;
         end else begin
            sender_idle_on = ($urandom_range(0, 2) != 0);
         end
         repeat (phase_len) begin
            send_item(random_req(kind));
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
